>>> design/dfc_pkg.sv
// Shared types and constants for the direct-form FIR convolution block.
`default_nettype none

package dfc_pkg;

    localparam int TAPS_DEF        = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IDX_W           = 6;   // tap_index field width
    localparam int TC_W            = 7;   // tap_count register width
    localparam int TC_RESET        = 1;
    localparam int ACC_W           = 64;  // saturating accumulator width

    // command queue between front and back; depth must stay a power of two
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t              kind;
        logic [IDX_W-1:0] index;
        logic             last;
    } cmd_ctrl_t;

    typedef enum logic [1:0]
    {
        B_IDLE,
        B_MAC,
        B_DRAIN,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

>>> design/dfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/dfc_front.sv
// Front end: accepts input items, classifies them and queues commands for the back end.
`default_nettype none

module dfc_front
    import dfc_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic        [IDX_W-1:0]       tap_index,
    input  wire logic signed [SAMPLE_BITS-1:0] coefficient,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output cmd_ctrl_t                          cmd_ctrl,
    output logic signed      [SAMPLE_BITS-1:0] cmd_data
);

    cmd_ctrl_t                      ctrl_reg [QDEPTH];
    logic signed [SAMPLE_BITS-1:0]  data_reg [QDEPTH];
    logic [QAW-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]                   count_reg, count_next;

    cmd_ctrl_t                      in_ctrl;
    logic signed [SAMPLE_BITS-1:0]  in_data;
    logic                           is_sample;
    logic                           keep;
    logic                           push;
    logic                           pop;

    // loads to slots beyond the store are taken and dropped
    assign is_sample = (op == OP_SAMPLE);
    assign keep      = is_sample || (32'(tap_index) < TAPS);

    always_comb
    begin
        in_ctrl.kind  = is_sample ? OP_SAMPLE : OP_LOAD;
        in_ctrl.index = tap_index;
        in_ctrl.last  = last & is_sample;
        in_data       = is_sample ? sample : coefficient;
    end

    assign in_ready  = (count_reg != (QAW+1)'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push      = in_valid && in_ready && keep;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_ctrl  = ctrl_reg[rd_ptr_reg];
    assign cmd_data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_reg[wr_ptr_reg] <= in_ctrl;
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> design/dfc_back.sv
// Back end: coefficient and history stores, one-MAC-per-cycle filter engine, output register.
`default_nettype none

module dfc_back
    import dfc_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire cmd_ctrl_t                     cmd_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] cmd_data,
    input  wire logic        [TC_W-1:0]        tap_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [SAMPLE_BITS-1:0] out_sample,
    output logic                               out_last
);

    localparam int AW   = $clog2(TAPS);
    localparam int CW   = $clog2(TAPS + 1);
    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int PW   = 2 * SAMPLE_BITS;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Y_MAX   =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN   = ~Y_MAX;

    back_state_t                   state_reg, state_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 fill_reg, fill_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic [CW-1:0]                 tail_reg, tail_next;
    logic                          last_reg, last_next;
    logic                          v1_reg, v1_next;
    logic                          z1_reg, z1_next;
    logic                          v2_reg, v2_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_last_reg, out_last_next;

    logic                          coeff_we;
    logic [SAMPLE_BITS-1:0]        coeff_rdata;
    logic                          hist_we;
    logic [SAMPLE_BITS-1:0]        hist_wdata;
    logic [SAMPLE_BITS-1:0]        hist_rdata;
    logic                          issue;

    logic [CW-1:0]                 active_n;
    logic [AW-1:0]                 head_inc;
    logic [AW-1:0]                 rd_dec;
    logic [CW-1:0]                 fill_inc;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       sum;
    logic                          ovf;
    logic signed [ACC_W-1:0]       acc_sat;
    logic signed [ACC_W-1:0]       shifted;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          out_free;

    dfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_coeff_ram (
        .clk     (clk),
        .wr_en   (coeff_we),
        .wr_addr (AW'(cmd_ctrl.index)),
        .wr_data (cmd_data),
        .rd_addr (AW'(cnt_reg)),
        .rd_data (coeff_rdata)
    );

    // history is a circular buffer; head points at the newest sample
    dfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (head_inc),
        .wr_data (hist_wdata),
        .rd_addr (rd_addr_reg),
        .rd_data (hist_rdata)
    );

    always_comb
    begin
        if (tap_count == '0)
        begin
            active_n = CW'(1);
        end
        else if (32'(tap_count) > TAPS)
        begin
            active_n = CW'(TAPS);
        end
        else
        begin
            active_n = CW'(tap_count);
        end
    end

    assign head_inc = (head_reg == AW'(TAPS - 1)) ? '0 : head_reg + 1'b1;
    assign rd_dec   = (rd_addr_reg == '0) ? AW'(TAPS - 1) : rd_addr_reg - 1'b1;
    assign fill_inc = (fill_reg == CW'(TAPS)) ? fill_reg : fill_reg + 1'b1;

    // saturating accumulate
    assign prod_ext = ACC_W'(prod_reg);
    assign sum      = acc_reg + prod_ext;
    assign ovf      = (acc_reg[ACC_W-1] == prod_ext[ACC_W-1]) &&
                      (sum[ACC_W-1] != acc_reg[ACC_W-1]);
    assign acc_sat  = ovf ? (acc_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;

    // floor shift then clamp to the sample range
    assign shifted = acc_reg >>> FRAC;
    always_comb
    begin
        if (shifted > Y_MAX)
        begin
            y = Y_MAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < Y_MIN)
        begin
            y = Y_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // MAC pipeline: RAM read, multiply, accumulate
    always_comb
    begin
        v1_next = issue;
        z1_next = (cnt_reg >= fill_reg);   // older than anything written: reads as zero
        v2_next = v1_reg;
        if (z1_reg)
        begin
            prod_next = '0;
        end
        else
        begin
            prod_next = $signed(coeff_rdata) * $signed(hist_rdata);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        rd_addr_next    = rd_addr_reg;
        tail_next       = tail_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        cmd_ready       = 1'b0;
        coeff_we        = 1'b0;
        hist_we         = 1'b0;
        hist_wdata      = '0;
        issue           = 1'b0;

        if (v2_reg)
        begin
            acc_next = acc_sat;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd_ctrl.kind == OP_LOAD)
                    begin
                        coeff_we = 1'b1;
                    end
                    else
                    begin
                        hist_we      = 1'b1;
                        hist_wdata   = cmd_data;
                        head_next    = head_inc;
                        fill_next    = fill_inc;
                        n_next       = active_n;
                        tail_next    = cmd_ctrl.last ? active_n - 1'b1 : '0;
                        last_next    = cmd_ctrl.last;
                        cnt_next     = '0;
                        rd_addr_next = head_inc;
                        acc_next     = '0;
                        state_next   = B_MAC;
                    end
                end
            end

            B_MAC:
            begin
                issue        = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                rd_addr_next = rd_dec;
                if (cnt_reg == n_reg - 1'b1)
                begin
                    state_next = B_DRAIN;
                end
            end

            B_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = B_OUT;
                end
            end

            B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = y;
                    out_last_next   = last_reg && (tail_reg == '0);
                    if (tail_reg != '0)
                    begin
                        // tail output: shift a zero into the delay line
                        tail_next    = tail_reg - 1'b1;
                        hist_we      = 1'b1;
                        head_next    = head_inc;
                        fill_next    = fill_inc;
                        cnt_next     = '0;
                        rd_addr_next = head_inc;
                        acc_next     = '0;
                        state_next   = B_MAC;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            fill_next = '0;   // end of signal clears the history
                        end
                        last_next  = 1'b0;
                        state_next = B_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            n_reg         <= CW'(1);
            cnt_reg       <= '0;
            rd_addr_reg   <= '0;
            tail_reg      <= '0;
            last_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            rd_addr_reg   <= rd_addr_next;
            tail_reg      <= tail_next;
            last_reg      <= last_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg         <= z1_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

>>> design/direct_fir_convolution.sv
// Direct-form FIR linear convolution of a sample stream with a stored impulse response.
// Input channel (in_valid/in_ready): op selects a coefficient load (tap_index, coefficient)
// or a sample (sample, last). A load gives no output; a sample gives one output, and a
// sample marked last also gives n-1 tail outputs, n being tap_count clamped to 1..TAPS;
// then the delay line is cleared. out_last marks the final output of a signal.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes tap_count; write it only while idle.
// Throughput: each output is computed by the single multiply-accumulate unit stepping one
// tap per cycle through the coefficient and history RAMs (one read port each). A load is
// written from the back end's idle state. A two-entry command
// queue lets the input side accept items while the back end is busy.
// Results sit in an output register; when the receiver stalls the engine holds its
// finished result, the queue fills and in_ready drops.
// Reset: tap_count returns to 1, the delay line reads as all zero (fill count cleared),
// the queue and output register empty. Coefficients are undefined until loaded.
`default_nettype none

module direct_fir_convolution
    import dfc_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [TC_W-1:0]        cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic        [IDX_W-1:0]       tap_index,
    input  wire logic signed [SAMPLE_BITS-1:0] coefficient,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [SAMPLE_BITS-1:0] out_sample,
    output logic                               out_last
);

    logic [TC_W-1:0]               tap_count_reg, tap_count_next;
    logic                          cmd_valid;
    logic                          cmd_ready;
    cmd_ctrl_t                     cmd_ctrl;
    logic signed [SAMPLE_BITS-1:0] cmd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tap_count_next = tap_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            tap_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TC_W'(TC_RESET);
        end
        else
        begin
            tap_count_reg <= tap_count_next;
        end
    end

    dfc_front #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .tap_index   (tap_index),
        .coefficient (coefficient),
        .sample      (sample),
        .last        (last),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_ctrl    (cmd_ctrl),
        .cmd_data    (cmd_data)
    );

    dfc_back #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_ctrl   (cmd_ctrl),
        .cmd_data   (cmd_data),
        .tap_count  (tap_count_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .out_last   (out_last)
    );

endmodule

`default_nettype wire
